// File: rtl/obstacle_point_merge_table_assert.svh
// Assertion macros used by the merge table top level.
`ifndef OBSTACLE_POINT_MERGE_TABLE_ASSERT_SVH
`define OBSTACLE_POINT_MERGE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define OPMT_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define OPMT_IMPLY(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define OPMT_ASSERT(label, cond)
`define OPMT_IMPLY(label, pre, post)
`endif
`endif

// File: rtl/opmt_pkg.sv
// Package: widths, status codes and register indexes of the merge table.
package opmt_pkg;
    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int OBJECT_IDS = 16;
    localparam int OID_W = $clog2(OBJECT_IDS);
    localparam logic [31:0] REFRESH_MS = 32'd500;
    localparam logic [7:0] NO_ID = 8'hFF;

    localparam logic [2:0] ST_FAR = 3'd0;
    localparam logic [2:0] ST_CHANGED = 3'd1;
    localparam logic [2:0] ST_SAME = 3'd2;
    localparam logic [2:0] ST_ADDED = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_SWEEP = 3'd5;
    localparam logic [2:0] ST_OFF = 3'd6;

    localparam logic [2:0] REG_LIMIT = 3'd0;
    localparam logic [2:0] REG_EXPIRY = 3'd1;
    localparam logic [2:0] REG_LEVEL = 3'd2;
    localparam logic [2:0] REG_SCALE = 3'd3;
    localparam logic [2:0] REG_RMIN = 3'd4;
    localparam logic [2:0] REG_DMAX = 3'd5;

    typedef struct packed {
        logic [7:0]  table_limit;
        logic [6:0]  expiry_seconds;
        logic [1:0]  output_level;
        logic [15:0] radius_scale;
        logic [9:0]  radius_min_cm;
        logic [9:0]  distance_max_cm;
    } cfg_t;

    typedef struct packed {
        logic signed [23:0] north;
        logic signed [23:0] east;
        logic signed [23:0] down;
        logic [31:0]        tstamp;
        logic [15:0]        radius;
        logic [7:0]         object;
        logic               send;
    } entry_t;
endpackage

// File: rtl/opmt_if.sv
// Valid/ready channel interfaces for points and results.
interface opmt_in_if (input logic clk);
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [23:0] pos_north;
    logic signed [23:0] pos_east;
    logic signed [23:0] pos_down;
    logic [15:0]        range_cm;
    logic [31:0]        time_ms;
    modport source (output valid, op, pos_north, pos_east, pos_down, range_cm, time_ms,
                    input ready);
    modport sink (input valid, op, pos_north, pos_east, pos_down, range_cm, time_ms,
                  output ready);
endinterface

interface opmt_out_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [6:0]  entry_index;
    logic [7:0]  object_number;
    logic        send_mark;
    logic [15:0] point_radius_cm;
    logic [7:0]  removed_count;
    logic [7:0]  entry_count;
    modport source (output valid, status, entry_index, object_number, send_mark,
                    point_radius_cm, removed_count, entry_count, input ready);
    modport sink (input valid, status, entry_index, object_number, send_mark,
                  point_radius_cm, removed_count, entry_count, output ready);
endinterface

// File: rtl/obstacle_point_merge_table.sv
// Top level: obstacle point merge table with sequencer and entry memory.
//
// channel   dir   handshake     word
// pt        in    valid/ready   op, position, range, time
// res       out   valid/ready   status, index, id, mark, radius, counts
// apb       in    psel/penable  configuration registers
//
// A push scans used entries one per cycle through the memory read register
// and the distance magnitude, square and sum stages; a tick reads and checks
// each entry and refills each removed slot. The entry memory port sets the pace.
// Reset clears the count and per-id counts at once; no clearing pass.
// ready is low while an item is in work or its result waits.
module obstacle_point_merge_table (
    input  logic        clk,
    input  logic        rst_n,
    opmt_in_if.sink     pt,
    opmt_out_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import opmt_pkg::*;
    `include "obstacle_point_merge_table_assert.svh"

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RAD   = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_DRAIN = 10'b0000001000,
        S_ADD   = 10'b0000010000,
        S_SWRD  = 10'b0000100000,
        S_SWCK  = 10'b0001000000,
        S_SWMV  = 10'b0010000000,
        S_SWWR  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    cfg_t cfg;
    opmt_regs u_regs (.clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable),
                      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
                      .pready(pready), .cfg(cfg));

    entry_t mem [TABLE_DEPTH];
    entry_t rd_reg;
    entry_t rd_keep_reg;
    entry_t kp_reg [2];
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    state_t state_reg, state_next;
    logic [CNT_W-1:0] used_reg;
    logic [7:0] ppo_reg [OBJECT_IDS];
    logic signed [23:0] pn_reg, pe_reg, pd_reg;
    logic [15:0] range_reg;
    logic [31:0] now_reg;
    logic [15:0] rad_reg;
    logic [31:0] prod_reg;
    logic [CNT_W-1:0] rcnt_reg;       // read issue index
    logic [CNT_W-1:0] chk_reg;        // index of entry at pipe output
    logic [CNT_W-1:0] swi_reg;
    logic [IDX_W-1:0] vidx_reg [4];   // pipe index taps
    logic [3:0]       vld_reg;
    logic [15:0]      erad_reg [1:3];
    logic [7:0]       eobj_reg [1:3];
    logic [31:0]      etim_reg [1:3];
    logic             esnd_reg [1:3];
    logic             found_reg, have_reg;
    logic [50:0]      best_reg;
    logic [7:0]       bobj_reg;
    logic [32:0]      rsq_reg;
    logic [34:0]      r2sq_reg;
    logic [31:0]      expms_reg;
    logic [7:0]       removed_reg;
    logic [2:0]       st_reg;
    logic [6:0]       oidx_reg;
    logic [7:0]       oobj_reg;
    logic             osnd_reg;
    logic [50:0]      dsq;
    logic             sendf;
    logic [CNT_W-1:0] lim;
    logic             pvld;
    logic [IDX_W-1:0] pidx;
    logic [32:0]      ersq;
    logic             hit;
    logic             changed;
    logic [7:0]       fid;
    logic [7:0]       newid;
    logic             far;

    assign sendf = cfg.output_level >= 2'd2;
    assign lim = (cfg.table_limit > 8'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(cfg.table_limit);
    assign far = (cfg.distance_max_cm != 10'd0) && (range_reg > 16'(cfg.distance_max_cm));

    opmt_dist u_dist (.clk(clk), .an(rd_reg.north), .ae(rd_reg.east), .ad(rd_reg.down),
                      .bn(pn_reg), .be(pe_reg), .bd(pd_reg), .dsq(dsq));

    assign pvld = vld_reg[3];
    assign pidx = vidx_reg[3];
    assign ersq = 33'(erad_reg[3]) * 33'(erad_reg[3]);
    assign hit = pvld && !found_reg && ((dsq < 51'(rsq_reg)) || (dsq < 51'(ersq)));
    assign changed = (erad_reg[3] != rad_reg) || ((now_reg - etim_reg[3]) >= REFRESH_MS);

    always_comb
    begin
        fid = NO_ID;
        for (int i = OBJECT_IDS - 1; i >= 0; i--)
            if (ppo_reg[i] == 8'd0)
                fid = 8'(i);
    end
    assign newid = (have_reg && best_reg < 51'(r2sq_reg)) ? bobj_reg : fid;

    assign pt.ready = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_OUT);
    assign res.status = st_reg;
    assign res.entry_index = oidx_reg;
    assign res.object_number = oobj_reg;
    assign res.send_mark = osnd_reg;
    assign res.point_radius_cm = (st_reg == ST_SWEEP || st_reg == ST_OFF) ? 16'd0 : rad_reg;
    assign res.removed_count = removed_reg;
    assign res.entry_count = 8'(used_reg);

    always_comb
    begin
        state_next = state_reg;
        raddr = rcnt_reg[IDX_W-1:0];
        we = 1'b0;
        waddr = pidx;
        wdata = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pt.valid)
                    state_next = (cfg.table_limit == 8'd0) ? S_OUT
                               : (pt.op ? S_SWRD : S_RAD);
            end
            S_RAD:
                state_next = far ? S_OUT : S_SCAN;
            S_SCAN:
            begin
                raddr = rcnt_reg[IDX_W-1:0];
                // A refresh touches only time, radius and send of the entry.
                if (hit && changed)
                begin
                    we = 1'b1;
                    wdata = rd_keep_reg;
                    wdata.tstamp = now_reg;
                    wdata.radius = rad_reg;
                    wdata.send = sendf;
                end
                if (hit)
                    state_next = S_OUT;
                else if (chk_reg >= used_reg)
                    state_next = S_ADD;
            end
            S_DRAIN:
                state_next = S_ADD;
            S_ADD:
            begin
                if (!found_reg && used_reg < lim)
                begin
                    we = 1'b1;
                    waddr = used_reg[IDX_W-1:0];
                    wdata = '{north: pn_reg, east: pe_reg, down: pd_reg, tstamp: now_reg,
                              radius: rad_reg, object: newid, send: sendf};
                end
                state_next = S_OUT;
            end
            S_SWRD:
            begin
                raddr = swi_reg[IDX_W-1:0];
                if (cfg.expiry_seconds == 7'd0 || swi_reg >= used_reg)
                    state_next = S_OUT;
                else
                    state_next = S_SWCK;
            end
            S_SWCK:
            begin
                if ((now_reg - rd_reg.tstamp) > expms_reg)
                    state_next = S_SWMV;
                else
                    state_next = S_SWRD;
            end
            S_SWMV:
            begin
                // The count has already dropped, so it now names the last entry.
                raddr = used_reg[IDX_W-1:0];
                state_next = S_SWWR;
            end
            S_SWWR:
            begin
                we = (swi_reg != used_reg);
                waddr = swi_reg[IDX_W-1:0];
                wdata = rd_reg;
                wdata.send = sendf;
                state_next = S_SWRD;
            end
            S_OUT:
                if (res.ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        kp_reg[0] <= rd_reg;
        kp_reg[1] <= kp_reg[0];
        rd_keep_reg <= kp_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            for (int i = 0; i < OBJECT_IDS; i++)
                ppo_reg[i] <= 8'd0;
            vld_reg <= '0;
            found_reg <= 1'b0;
            have_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Words still in the pipe are flushed once the scan ends.
            vld_reg <= (state_reg == S_SCAN)
                     ? {vld_reg[2:0], rcnt_reg < used_reg && !found_reg} : 4'b0000;
            if (state_reg == S_IDLE && pt.valid)
            begin
                found_reg <= 1'b0;
                have_reg <= 1'b0;
            end
            if (state_reg == S_SCAN && pvld && !found_reg)
            begin
                if (!have_reg || dsq < best_reg)
                begin
                    have_reg <= 1'b1;
                end
                if (hit)
                    found_reg <= 1'b1;
            end
            if (state_reg == S_ADD && !found_reg && used_reg < lim)
            begin
                used_reg <= used_reg + 1'b1;
                if (newid < 8'(OBJECT_IDS) && ppo_reg[newid[OID_W-1:0]] != 8'd255)
                    ppo_reg[newid[OID_W-1:0]] <= ppo_reg[newid[OID_W-1:0]] + 8'd1;
            end
            if (state_reg == S_SWCK && (now_reg - rd_reg.tstamp) > expms_reg)
            begin
                used_reg <= used_reg - 1'b1;
                if (rd_reg.object < 8'(OBJECT_IDS) && ppo_reg[rd_reg.object[OID_W-1:0]] != 8'd0)
                    ppo_reg[rd_reg.object[OID_W-1:0]] <= ppo_reg[rd_reg.object[OID_W-1:0]] - 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vidx_reg[0] <= rcnt_reg[IDX_W-1:0];
        for (int i = 1; i < 4; i++)
            vidx_reg[i] <= vidx_reg[i-1];
        // Entry fields join the pipe in the cycle after the address.
        erad_reg[1] <= rd_reg.radius;
        eobj_reg[1] <= rd_reg.object;
        etim_reg[1] <= rd_reg.tstamp;
        esnd_reg[1] <= rd_reg.send;
        for (int i = 2; i < 4; i++)
        begin
            erad_reg[i] <= erad_reg[i-1];
            eobj_reg[i] <= eobj_reg[i-1];
            etim_reg[i] <= etim_reg[i-1];
            esnd_reg[i] <= esnd_reg[i-1];
        end
        case (state_reg)
            S_IDLE:
            begin
                pn_reg <= pt.pos_north;
                pe_reg <= pt.pos_east;
                pd_reg <= pt.pos_down;
                range_reg <= pt.range_cm;
                now_reg <= pt.time_ms;
                prod_reg <= 32'(pt.range_cm) * 32'(cfg.radius_scale);
                rcnt_reg <= '0;
                chk_reg <= '0;
                swi_reg <= '0;
                removed_reg <= 8'd0;
                expms_reg <= 32'(cfg.expiry_seconds) * 32'd1000;
                st_reg <= pt.op ? ST_SWEEP : ST_FAR;
                rad_reg <= 16'd0;
                oidx_reg <= 7'd0;
                oobj_reg <= 8'd0;
                osnd_reg <= 1'b0;
                if (cfg.table_limit == 8'd0)
                    st_reg <= ST_OFF;
            end
            S_RAD:
            begin
                logic [16:0] sc;
                logic [15:0] r;
                sc = 17'((33'(prod_reg) + 33'd32768) >> 16);
                r = (sc > 17'(cfg.radius_min_cm)) ? sc[15:0] : 16'(cfg.radius_min_cm);
                rad_reg <= r;
                rsq_reg <= 33'(r) * 33'(r);
                r2sq_reg <= {33'(r) * 33'(r), 2'b00};
            end
            S_SCAN:
            begin
                if (rcnt_reg < used_reg)
                    rcnt_reg <= rcnt_reg + 1'b1;
                if (pvld)
                    chk_reg <= chk_reg + 1'b1;
                if (pvld && !found_reg && (!have_reg || dsq < best_reg))
                begin
                    best_reg <= dsq;
                    bobj_reg <= eobj_reg[3];
                end
                if (hit)
                begin
                    st_reg <= changed ? ST_CHANGED : ST_SAME;
                    oidx_reg <= 7'(pidx);
                    oobj_reg <= eobj_reg[3];
                    osnd_reg <= changed ? sendf : esnd_reg[3];
                end
            end
            S_ADD:
            begin
                if (!found_reg)
                begin
                    if (used_reg < lim)
                    begin
                        st_reg <= ST_ADDED;
                        oidx_reg <= 7'(used_reg);
                        oobj_reg <= newid;
                        osnd_reg <= sendf;
                    end
                    else
                        st_reg <= ST_FULL;
                end
            end
            S_SWCK:
                if ((now_reg - rd_reg.tstamp) > expms_reg)
                    removed_reg <= removed_reg + 8'd1;
                else
                    swi_reg <= swi_reg + 1'b1;
            default: ;
        endcase
    end

    `OPMT_IMPLY(a_out_hold, res.valid && !res.ready, res.valid)
    `OPMT_ASSERT(a_used_bound, used_reg <= CNT_W'(TABLE_DEPTH))
    `OPMT_ASSERT(a_ready_excl, !(pt.ready && res.valid))
endmodule

// File: rtl/opmt_regs.sv
// APB-style configuration registers.
module opmt_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output opmt_pkg::cfg_t    cfg
);
    import opmt_pkg::*;
    cfg_t cfg_reg;
    logic [2:0] sel;
    assign sel = paddr[4:2];
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.table_limit <= 8'd100;
            cfg_reg.expiry_seconds <= 7'd10;
            cfg_reg.output_level <= 2'd1;
            cfg_reg.radius_scale <= 16'd5734;
            cfg_reg.radius_min_cm <= 10'd1;
            cfg_reg.distance_max_cm <= 10'd0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            unique case (sel)
                REG_LIMIT:  cfg_reg.table_limit <= pwdata[7:0];
                REG_EXPIRY: cfg_reg.expiry_seconds <= pwdata[6:0];
                REG_LEVEL:  cfg_reg.output_level <= pwdata[1:0];
                REG_SCALE:  cfg_reg.radius_scale <= pwdata[15:0];
                REG_RMIN:   cfg_reg.radius_min_cm <= pwdata[9:0];
                REG_DMAX:   cfg_reg.distance_max_cm <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (sel)
            REG_LIMIT:  prdata = {24'd0, cfg_reg.table_limit};
            REG_EXPIRY: prdata = {25'd0, cfg_reg.expiry_seconds};
            REG_LEVEL:  prdata = {30'd0, cfg_reg.output_level};
            REG_SCALE:  prdata = {16'd0, cfg_reg.radius_scale};
            REG_RMIN:   prdata = {22'd0, cfg_reg.radius_min_cm};
            REG_DMAX:   prdata = {22'd0, cfg_reg.distance_max_cm};
            default:    prdata = '0;
        endcase
    end
endmodule

// File: rtl/opmt_dist.sv
// Pipelined squared distance between a stored entry and the point.
module opmt_dist (
    input  logic               clk,
    input  logic signed [23:0] an,
    input  logic signed [23:0] ae,
    input  logic signed [23:0] ad,
    input  logic signed [23:0] bn,
    input  logic signed [23:0] be,
    input  logic signed [23:0] bd,
    output logic [50:0]        dsq
);
    logic [24:0] dn_reg, de_reg, dd_reg;
    logic [49:0] sn_reg, se_reg, sd_reg;
    logic signed [24:0] xn, xe, xd;

    always_comb
    begin
        xn = 25'(an) - 25'(bn);
        xe = 25'(ae) - 25'(be);
        xd = 25'(ad) - 25'(bd);
    end

    // Stage 1 keeps magnitudes, stage 2 squares, stage 3 sums.
    always_ff @(posedge clk)
    begin
        dn_reg <= xn[24] ? 25'(-xn) : 25'(xn);
        de_reg <= xe[24] ? 25'(-xe) : 25'(xe);
        dd_reg <= xd[24] ? 25'(-xd) : 25'(xd);
        sn_reg <= 50'(dn_reg) * 50'(dn_reg);
        se_reg <= 50'(de_reg) * 50'(de_reg);
        sd_reg <= 50'(dd_reg) * 50'(dd_reg);
        dsq <= 51'(sn_reg) + 51'(se_reg) + 51'(sd_reg);
    end
endmodule

// File: dv/testbench.sv
// Self-checking testbench for the obstacle point merge table.
`timescale 1ns / 100ps

module testbench;
    import opmt_pkg::*;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct {
        logic               op;
        logic signed [23:0] north;
        logic signed [23:0] east;
        logic signed [23:0] down;
        logic [15:0]        range_cm;
        logic [31:0]        time_ms;
    } point_t;

    typedef struct {
        logic [2:0]  status;
        logic [6:0]  entry_index;
        logic [7:0]  object_number;
        logic        send_mark;
        logic [15:0] radius;
        logic [7:0]  removed;
        logic [7:0]  count;
    } outcome_t;

    // Tracks the table contents and the outcomes still owed by the block.
    class merge_scoreboard;
        int unsigned limit, expiry, level, scale, rmin, dmax;
        int          st_north[TABLE_DEPTH], st_east[TABLE_DEPTH], st_down[TABLE_DEPTH];
        logic [31:0] st_time[TABLE_DEPTH];
        int unsigned st_radius[TABLE_DEPTH], st_object[TABLE_DEPTH];
        bit          st_send[TABLE_DEPTH];
        int unsigned used;
        int unsigned per_object[OBJECT_IDS];
        outcome_t    owed[$];
        int          errors;

        function new();
            limit = 100; expiry = 10; level = 1; scale = 5734; rmin = 1; dmax = 0;
            used = 0; errors = 0;
            foreach (per_object[i]) per_object[i] = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_LIMIT:  limit = v[7:0];
                REG_EXPIRY: expiry = v[6:0];
                REG_LEVEL:  level = v[1:0];
                REG_SCALE:  scale = v[15:0];
                REG_RMIN:   rmin = v[9:0];
                REG_DMAX:   dmax = v[9:0];
                default: ;
            endcase
        endfunction

        function bit mark();
            return level >= 2;
        endfunction

        function int unsigned lowest_free_id();
            for (int i = 0; i < OBJECT_IDS; i++)
                if (per_object[i] == 0) return i;
            return NO_ID;
        endfunction

        // Removal fills the hole with the last entry.
        function void drop_entry(int idx);
            int unsigned id;
            id = st_object[idx];
            if (id < OBJECT_IDS && per_object[id] > 0) per_object[id]--;
            used--;
            if (idx != used) begin
                st_north[idx] = st_north[used];
                st_east[idx] = st_east[used];
                st_down[idx] = st_down[used];
                st_time[idx] = st_time[used];
                st_radius[idx] = st_radius[used];
                st_object[idx] = st_object[used];
                st_send[idx] = mark();
            end
        endfunction

        function void note_point(point_t p);
            outcome_t          r;
            longint unsigned   scaled, rsq, best, d, er, r2;
            longint            dx, dy, dz;
            int unsigned       rad, id, lim;
            logic [31:0]       age;
            bit                have_best, found, changed;
            int                best_i, i;
            r = '{default: 0};
            rad = 0;
            if (limit == 0) begin
                r.status = ST_OFF;
            end
            else if (p.op == OP_TICK) begin
                r.status = ST_SWEEP;
                if (expiry != 0) begin
                    i = 0;
                    while (i < used) begin
                        age = p.time_ms - st_time[i];
                        if (age > expiry * 1000) begin
                            drop_entry(i);
                            r.removed++;
                        end
                        else
                            i++;
                    end
                end
            end
            else begin
                scaled = (longint'(p.range_cm) * scale + 32768) >> 16;
                rad = (scaled > rmin) ? int'(scaled) : rmin;
                if (dmax != 0 && p.range_cm > dmax) begin
                    r.status = ST_FAR;
                end
                else begin
                    rsq = longint'(rad) * rad;
                    have_best = 0; found = 0; best = 0; best_i = 0;
                    for (i = 0; i < used; i++) begin
                        dx = longint'(st_north[i]) - longint'(p.north);
                        dy = longint'(st_east[i]) - longint'(p.east);
                        dz = longint'(st_down[i]) - longint'(p.down);
                        d = dx * dx + dy * dy + dz * dz;
                        er = st_radius[i];
                        if (!have_best || d < best) begin
                            have_best = 1; best = d; best_i = i;
                        end
                        if (d < rsq || d < er * er) begin
                            age = p.time_ms - st_time[i];
                            changed = (st_radius[i] != rad) || (age >= REFRESH_MS);
                            if (changed) begin
                                st_time[i] = p.time_ms;
                                st_radius[i] = rad;
                                st_send[i] = mark();
                                r.status = ST_CHANGED;
                            end
                            else
                                r.status = ST_SAME;
                            r.entry_index = 7'(i);
                            r.object_number = 8'(st_object[i]);
                            r.send_mark = st_send[i];
                            found = 1;
                            break;
                        end
                    end
                    if (!found) begin
                        r2 = 2 * longint'(rad);
                        if (have_best && best < r2 * r2) id = st_object[best_i];
                        else id = lowest_free_id();
                        lim = (limit > TABLE_DEPTH) ? TABLE_DEPTH : limit;
                        if (used >= lim) begin
                            r.status = ST_FULL;
                        end
                        else begin
                            st_north[used] = p.north;
                            st_east[used] = p.east;
                            st_down[used] = p.down;
                            st_time[used] = p.time_ms;
                            st_radius[used] = rad;
                            st_object[used] = id;
                            st_send[used] = mark();
                            if (id < OBJECT_IDS && per_object[id] < 255) per_object[id]++;
                            r.status = ST_ADDED;
                            r.entry_index = 7'(used);
                            r.object_number = 8'(id);
                            r.send_mark = mark();
                            used++;
                        end
                    end
                end
            end
            r.radius = rad[15:0];
            r.count = 8'(used);
            owed.push_back(r);
        endfunction

        function void check_result(outcome_t got);
            outcome_t w;
            if (owed.size() == 0) begin
                $display("%0t: result with nothing outstanding, status %0d", $time, got.status);
                errors++;
                return;
            end
            w = owed.pop_front();
            if (got.status !== w.status) begin
                $display("%0t: status exp %0d got %0d", $time, w.status, got.status);
                errors++;
            end
            if (got.entry_index !== w.entry_index) begin
                $display("%0t: entry_index exp %0d got %0d", $time, w.entry_index,
                         got.entry_index);
                errors++;
            end
            if (got.object_number !== w.object_number) begin
                $display("%0t: object_number exp %0d got %0d", $time, w.object_number,
                         got.object_number);
                errors++;
            end
            if (got.send_mark !== w.send_mark) begin
                $display("%0t: send_mark exp %0d got %0d", $time, w.send_mark, got.send_mark);
                errors++;
            end
            if (got.radius !== w.radius) begin
                $display("%0t: point_radius_cm exp %0d got %0d", $time, w.radius, got.radius);
                errors++;
            end
            if (got.removed !== w.removed) begin
                $display("%0t: removed_count exp %0d got %0d", $time, w.removed, got.removed);
                errors++;
            end
            if (got.count !== w.count) begin
                $display("%0t: entry_count exp %0d got %0d", $time, w.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    opmt_in_if  pt (clk);
    opmt_out_if res (clk);

    obstacle_point_merge_table u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pt      (pt.sink),
        .res     (res.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    merge_scoreboard sb = new();
    bit          calm;
    int          stall_left;
    logic [31:0] clock_ms;
    int          centers[8][3];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("obstacle_point_merge_table test failed");
        $finish;
    end

    function automatic int gap_len();
        int k;
        if (calm) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random back-pressure.
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res.ready <= 1'b0;
        end
        else begin
            stall_left <= gap_len();
            res.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (res.valid && res.ready)
            sb.check_result('{res.status, res.entry_index, res.object_number, res.send_mark,
                              res.point_radius_cm, res.removed_count, res.entry_count});
    end

    task automatic send_point(point_t p);
        int g;
        g = gap_len();
        if (g > 0) begin
            pt.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        pt.valid <= 1'b1;
        pt.op <= p.op;
        pt.pos_north <= p.north;
        pt.pos_east <= p.east;
        pt.pos_down <= p.down;
        pt.range_cm <= p.range_cm;
        pt.time_ms <= p.time_ms;
        do @(posedge clk); while (!pt.ready);
        sb.note_point(p);
    endtask

    task automatic drain();
        pt.valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, v);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic configure(int lim, int ex, int lv, int sc, int rm, int dm);
        drain();
        write_reg(REG_LIMIT, lim);
        write_reg(REG_EXPIRY, ex);
        write_reg(REG_LEVEL, lv);
        write_reg(REG_SCALE, sc);
        write_reg(REG_RMIN, rm);
        write_reg(REG_DMAX, dm);
    endtask

    function automatic point_t mk(logic op, int n, int e, int d, int rg, logic [31:0] t);
        point_t p;
        p.op = op; p.north = 24'(n); p.east = 24'(e); p.down = 24'(d);
        p.range_cm = 16'(rg); p.time_ms = t;
        return p;
    endfunction

    // Mostly points clustered around a few centers, with ticks and pure noise.
    function automatic point_t random_point();
        point_t p;
        int c, k;
        k = $urandom_range(0, 99);
        if (k < 30)
            clock_ms += $urandom_range(0, 120);
        else if (k < 97)
            clock_ms += $urandom_range(100, 700);
        else
            clock_ms += $urandom_range(3000, 15000);
        k = $urandom_range(0, 99);
        if (k < 10)
            return mk(OP_TICK, $urandom(), $urandom(), $urandom(), $urandom(), clock_ms);
        if (k < 15)
            return mk(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom());
        c = $urandom_range(0, 7);
        p = mk(OP_PUSH, centers[c][0] + $urandom_range(0, 80) - 40,
               centers[c][1] + $urandom_range(0, 80) - 40,
               centers[c][2] + $urandom_range(0, 80) - 40,
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 1200),
               clock_ms);
        return p;
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_point(random_point());
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        pt.valid = 1'b0; pt.op = OP_PUSH; pt.pos_north = '0; pt.pos_east = '0;
        pt.pos_down = '0; pt.range_cm = '0; pt.time_ms = '0;
        res.ready = 1'b0;
        stall_left = 0;
        calm = 1'b0;
        clock_ms = 32'hFFFF_0000;
        foreach (centers[i]) begin
            centers[i][0] = $urandom_range(0, 4000) - 2000;
            centers[i][1] = $urandom_range(0, 4000) - 2000;
            centers[i][2] = $urandom_range(0, 400) - 200;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, merge, refresh, full table, reject, expiry, disabled.
        send_point(mk(OP_PUSH, 0, 0, 0, 0, 0));
        send_point(mk(OP_PUSH, 0, 0, 0, 0, 0));
        send_point(mk(OP_PUSH, 0, 0, 0, 0, 600));
        send_point(mk(OP_PUSH, 1, 0, 0, 100, 700));
        send_point(mk(OP_PUSH, -8388608, -8388608, -8388608, 65535, 1000));
        send_point(mk(OP_PUSH, 8388607, 8388607, 8388607, 65535, 32'hFFFF_FFFF));
        send_point(mk(OP_PUSH, 5, 0, 0, 1, 1000));
        send_point(mk(OP_TICK, 0, 0, 0, 0, 5000));
        send_point(mk(OP_TICK, 0, 0, 0, 0, 32'h7FFF_0000));
        configure(3, 127, 3, 65535, 1000, 1000);
        send_point(mk(OP_PUSH, 0, 0, 0, 1001, 0));
        send_point(mk(OP_PUSH, 0, 0, 0, 1000, 0));
        send_point(mk(OP_PUSH, 10000, 0, 0, 0, 0));
        send_point(mk(OP_PUSH, 20000, 0, 0, 0, 0));
        send_point(mk(OP_PUSH, 30000, 0, 0, 0, 0));
        send_point(mk(OP_PUSH, 1500, 0, 0, 0, 100));
        send_point(mk(OP_TICK, 0, 0, 0, 0, 127000));
        send_point(mk(OP_TICK, 0, 0, 0, 0, 127001));
        configure(0, 0, 0, 0, 0, 0);
        send_point(mk(OP_PUSH, 0, 0, 0, 50, 0));
        send_point(mk(OP_TICK, 0, 0, 0, 0, 0));

        configure(100, 10, 1, 5734, 1, 0);
        random_phase(400);
        calm = 1'b1;
        configure(128, 3, 2, 20000, 20, 800);
        random_phase(300);
        calm = 1'b0;
        configure(2, 0, 3, 0, 0, 0);
        random_phase(150);
        configure(255, 1, 0, 65535, 1000, 1000);
        random_phase(300);
        configure(8, 2, 1, 1000, 50, 0);
        random_phase(250);
        configure(0, 5, 2, 5734, 1, 0);
        random_phase(50);
        configure(128, 127, 2, 3000, 5, 500);
        random_phase(300);
        configure(60, 4, 3, 8000, 10, 0);
        random_phase(250);

        drain();
        if (sb.errors == 0)
            $display("obstacle_point_merge_table test passed");
        else
            $display("obstacle_point_merge_table test failed");
        $finish;
    end
endmodule
